// ----- design/midi2usb_pkg.sv -----
package midi2usb_pkg;

    localparam logic [7:0] STATUS_SYSEX_START = 8'hF0;
    localparam logic [7:0] STATUS_QUARTER_FRAME = 8'hF1;
    localparam logic [7:0] STATUS_SONG_POSITION = 8'hF2;
    localparam logic [7:0] STATUS_SONG_SELECT = 8'hF3;
    localparam logic [7:0] STATUS_SYSEX_END = 8'hF7;
    localparam logic [7:0] STATUS_REALTIME_FIRST = 8'hF8;

    localparam logic [3:0] CIN_SYSCOM_TWO = 4'h2;
    localparam logic [3:0] CIN_SYSCOM_THREE = 4'h3;
    localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
    localparam logic [3:0] CIN_SINGLE_BYTE = 4'h5;

    typedef logic [7:0] midi_byte_t;
    typedef midi_byte_t [2:0] packet_bytes_t;

    function automatic logic [1:0] channel_msg_length(input logic [2:0] kind);
        logic [1:0] len;
        unique case (kind)
            3'd4, 3'd5: len = 2'd2;
            3'd7:       len = 2'd0;
            default:    len = 2'd3;
        endcase
        return len;
    endfunction

endpackage

// ----- design/midi_bytes_to_usb_midi_packets.sv -----
// Channel  Handshake             Payload
// in       in_valid / in_ready   midi_byte
// out      out_valid / out_ready cable, code_index, data_first, data_second, data_third
// cfg      cfg_write_en          cfg_write_data (cable number)
//
// Each byte is decoded from the input register, so one byte per cycle is taken while
// out_ready stays high; a packet is registered at the output when its last byte
// advances out of the input register. A byte that completes no packet moves on even
// while a packet waits at the output. Reset clears the parsing state, the cable
// number and both valid flags.
module midi_bytes_to_usb_midi_packets
    import midi2usb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [3:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] midi_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] cable,
    output logic [3:0] code_index,
    output logic [7:0] data_first,
    output logic [7:0] data_second,
    output logic [7:0] data_third
);

    logic [3:0]    cable_number_reg;
    logic          in_vld_reg;
    midi_byte_t    byte_reg;

    logic [7:0]    running_status_reg, running_status_next;
    logic [1:0]    message_length_reg, message_length_next;
    logic [1:0]    byte_index_reg, byte_index_next;
    logic          in_sysex_reg, in_sysex_next;
    logic [3:0]    pending_code_reg, pending_code_next;
    packet_bytes_t packet_bytes_reg, packet_bytes_next;

    logic          out_vld_reg;
    logic [3:0]    cable_reg;
    logic [3:0]    code_reg, code_next;
    packet_bytes_t out_bytes_reg, out_bytes_next;

    logic          emit;
    logic          advance;
    logic [2:0]    idx_inc;
    logic [1:0]    end_idx;
    packet_bytes_t filled;

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready || !emit);
    assign in_ready = !in_vld_reg || advance;

    always_comb
    begin
        running_status_next = running_status_reg;
        message_length_next = message_length_reg;
        byte_index_next     = byte_index_reg;
        in_sysex_next       = in_sysex_reg;
        pending_code_next   = pending_code_reg;
        packet_bytes_next   = packet_bytes_reg;
        emit                = 1'b0;
        code_next           = CIN_SINGLE_BYTE;
        out_bytes_next      = '0;
        idx_inc             = {1'b0, byte_index_reg} + 3'd1;
        end_idx             = (byte_index_reg > 2'd2) ? 2'd2 : byte_index_reg;
        filled              = packet_bytes_reg;

        priority if (byte_reg >= STATUS_REALTIME_FIRST)
        begin
            emit              = 1'b1;
            out_bytes_next[0] = byte_reg;
        end
        else if (byte_reg >= 8'h80 && byte_reg < STATUS_SYSEX_START)
        begin
            in_sysex_next       = 1'b0;
            running_status_next = byte_reg;
            pending_code_next   = byte_reg[7:4];
            message_length_next = channel_msg_length(byte_reg[6:4]);
            packet_bytes_next   = '{8'h00, 8'h00, byte_reg};
            byte_index_next     = 2'd1;
        end
        else if (byte_reg == STATUS_SYSEX_START)
        begin
            in_sysex_next       = 1'b1;
            running_status_next = byte_reg;
            pending_code_next   = CIN_SYSEX_CONT;
            message_length_next = 2'd3;
            packet_bytes_next   = '{8'h00, 8'h00, byte_reg};
            byte_index_next     = 2'd1;
        end
        else if (byte_reg == STATUS_SYSEX_END)
        begin
            emit = 1'b1;
            if (in_sysex_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    out_bytes_next[k] = (2'(k) < end_idx) ? packet_bytes_reg[k] : 8'h00;
                end
                out_bytes_next[end_idx] = STATUS_SYSEX_END;
                code_next = CIN_SINGLE_BYTE + {2'b00, end_idx};
            end
            else
            begin
                out_bytes_next[0] = STATUS_SYSEX_END;
            end
            in_sysex_next       = 1'b0;
            running_status_next = 8'h00;
            message_length_next = 2'd0;
            byte_index_next     = 2'd0;
            packet_bytes_next   = '0;
        end
        else if (byte_reg == STATUS_QUARTER_FRAME || byte_reg == STATUS_SONG_SELECT)
        begin
            in_sysex_next       = 1'b0;
            running_status_next = byte_reg;
            pending_code_next   = CIN_SYSCOM_TWO;
            message_length_next = 2'd2;
            packet_bytes_next   = '{8'h00, 8'h00, byte_reg};
            byte_index_next     = 2'd1;
        end
        else if (byte_reg == STATUS_SONG_POSITION)
        begin
            in_sysex_next       = 1'b0;
            running_status_next = byte_reg;
            pending_code_next   = CIN_SYSCOM_THREE;
            message_length_next = 2'd3;
            packet_bytes_next   = '{8'h00, 8'h00, byte_reg};
            byte_index_next     = 2'd1;
        end
        else if (byte_reg[7])
        begin
            emit                = 1'b1;
            out_bytes_next[0]   = byte_reg;
            in_sysex_next       = 1'b0;
            running_status_next = 8'h00;
            message_length_next = 2'd0;
            byte_index_next     = 2'd0;
            packet_bytes_next   = '0;
        end
        else if (running_status_reg != 8'h00)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (byte_index_reg == 2'(k))
                begin
                    filled[k] = byte_reg;
                end
            end
            packet_bytes_next = filled;
            if (idx_inc < {1'b0, message_length_reg} && idx_inc < 3'd3)
            begin
                byte_index_next = idx_inc[1:0];
            end
            else
            begin
                emit           = 1'b1;
                code_next      = pending_code_reg;
                out_bytes_next = filled;
                if (in_sysex_reg)
                begin
                    byte_index_next      = 2'd0;
                    packet_bytes_next[0] = 8'h00;
                end
                else
                begin
                    byte_index_next = 2'd1;
                end
                packet_bytes_next[1] = 8'h00;
                packet_bytes_next[2] = 8'h00;
                if (running_status_reg >= STATUS_QUARTER_FRAME)
                begin
                    running_status_next = 8'h00;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cable_number_reg   <= 4'd0;
            in_vld_reg         <= 1'b0;
            out_vld_reg        <= 1'b0;
            running_status_reg <= 8'h00;
            message_length_reg <= 2'd0;
            byte_index_reg     <= 2'd0;
            in_sysex_reg       <= 1'b0;
            pending_code_reg   <= 4'd0;
            packet_bytes_reg   <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                cable_number_reg <= cfg_write_data;
            end
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                running_status_reg <= running_status_next;
                message_length_reg <= message_length_next;
                byte_index_reg     <= byte_index_next;
                in_sysex_reg       <= in_sysex_next;
                pending_code_reg   <= pending_code_next;
                packet_bytes_reg   <= packet_bytes_next;
            end
            if (advance && emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= midi_byte;
        end
        if (advance && emit)
        begin
            cable_reg     <= cable_number_reg;
            code_reg      <= code_next;
            out_bytes_reg <= out_bytes_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign cable       = cable_reg;
    assign code_index  = code_reg;
    assign data_first  = out_bytes_reg[0];
    assign data_second = out_bytes_reg[1];
    assign data_third  = out_bytes_reg[2];

endmodule
